### hw/rtl/owj_pkg.sv
package owj_pkg;

  localparam int JOB_W = 16;
  localparam int OWN_W = 2;

  // request codes
  typedef enum logic [1:0] {
    REQ_HEAD   = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_FETCH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // result codes
  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_DELIVERED = 2'd1,
    ST_NOMATCH   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // broadcast from the top level to every cell; the request strobes are already gated by the beat
  typedef struct packed {
    logic             ins_head;
    logic             append;
    logic             fetch;
    logic [OWN_W-1:0] worker;
    logic [JOB_W-1:0] job_id;
  } cell_ctl_t;

endpackage

### hw/rtl/owj_cell.sv
module owj_cell import owj_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  logic [JOB_W-1:0] prev_job,
  input  logic [OWN_W-1:0] prev_owner,
  input  logic [JOB_W-1:0] next_job,
  input  logic [OWN_W-1:0] next_owner,
  input  logic             found_in,
  input  logic [JOB_W-1:0] got_in,
  output logic [JOB_W-1:0] job,
  output logic [OWN_W-1:0] owner,
  output logic             found_out,
  output logic [JOB_W-1:0] got_out
);

  logic [JOB_W-1:0] job_r, job_nxt;
  logic [OWN_W-1:0] owner_r, owner_nxt;
  logic             occupied;
  logic             hit;

  assign job   = job_r;
  assign owner = owner_r;

  // owner match, only inside the filled part of the row
  assign occupied  = count > CNT_W'(IDX);
  assign hit       = ctl.fetch & occupied & (owner_r == ctl.worker);
  assign found_out = found_in | hit;

  // first match from the head carries its job down the chain toward the tail
  always_comb begin
    if (found_in) begin
      got_out = got_in;
    end else if (hit) begin
      got_out = job_r;
    end else begin
      got_out = '0;
    end
  end

  // shift toward the tail on insert, fill on append, close the gap on fetch
  always_comb begin
    job_nxt   = job_r;
    owner_nxt = owner_r;
    if (ctl.ins_head) begin
      job_nxt   = prev_job;
      owner_nxt = prev_owner;
    end else if (ctl.append && (count == CNT_W'(IDX))) begin
      job_nxt   = ctl.job_id;
      owner_nxt = ctl.worker;
    end else if (found_out) begin
      job_nxt   = next_job;
      owner_nxt = next_owner;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    owner_r <= owner_nxt;
  end

endmodule

### hw/rtl/owner_tagged_job_deque.sv
// result: a result beat is registered and presented in the cycle after its request beat
// throughput: one request per cycle unless in_stall holds it; insert, append and gap closing all
//   finish in that cycle in the row of cells, the owner match ripples
//   through the row from head to tail
// reset: synchronous active-low rst_n empties the store and drops out_valid
module owner_tagged_job_deque import owj_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [OWN_W-1:0]             in_worker,
  input  logic [JOB_W-1:0]             in_job_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [JOB_W-1:0]             out_job_id,
  output logic [$clog2(DEPTH+1)-1:0]   out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [JOB_W-1:0] job_out_r, job_out_nxt;

  logic      go;
  logic      full;
  req_t      req;
  cell_ctl_t ctl;

  logic [JOB_W-1:0] job_w   [DEPTH];
  logic [OWN_W-1:0] owner_w [DEPTH];
  logic             found_w [DEPTH+1];
  logic [JOB_W-1:0] got_w   [DEPTH+1];

  // handshake: hold the request while an unread result waits
  assign in_stall = out_valid_r & out_stall;
  assign go       = in_valid & ~in_stall;
  assign full     = count_r == CNT_W'(DEPTH);
  assign req      = req_t'(in_req_type);

  // broadcast to the cells
  always_comb begin
    ctl.ins_head = go & (req == REQ_HEAD) & ~full;
    ctl.append   = go & (req == REQ_APPEND) & ~full;
    ctl.fetch    = go & (req == REQ_FETCH);
    ctl.worker   = in_worker;
    ctl.job_id   = in_job_id;
  end

  assign found_w[0] = 1'b0;
  assign got_w[0]   = '0;

  // row of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [JOB_W-1:0] pj, nj;
    logic [OWN_W-1:0] po, no;
    if (i == 0) begin : g_head
      assign pj = in_job_id;
      assign po = in_worker;
    end else begin : g_mid
      assign pj = job_w[i-1];
      assign po = owner_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nj = job_w[i];
      assign no = owner_w[i];
    end else begin : g_body
      assign nj = job_w[i+1];
      assign no = owner_w[i+1];
    end
    owj_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .prev_job   (pj),
      .prev_owner (po),
      .next_job   (nj),
      .next_owner (no),
      .found_in   (found_w[i]),
      .got_in     (got_w[i]),
      .job        (job_w[i]),
      .owner      (owner_w[i]),
      .found_out  (found_w[i+1]),
      .got_out    (got_w[i+1])
    );
  end

  // result and occupancy for this beat
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = status_r;
    job_out_nxt = job_out_r;
    if (go) begin
      job_out_nxt = '0;
      case (req)
        REQ_HEAD, REQ_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_STORED;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        REQ_FETCH: begin
          if (found_w[DEPTH]) begin
            status_nxt  = ST_DELIVERED;
            job_out_nxt = got_w[DEPTH];
            count_nxt   = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOMATCH;
          end
        end
        default: begin
          status_nxt = ST_NOMATCH;
        end
      endcase
    end
  end

  // output register valid
  always_comb begin
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    job_out_r <= job_out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_job_id    = job_out_r;
  assign out_occupancy = count_r;

  // occupancy never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job count above depth");

  // occupancy moves only on a request beat
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(count_r))
    else $error("job count changed without a request beat");

  // a refused job is reported only with a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full status with room left");

  // a delivered job leaves room behind it
  a_deliver_room: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (req == REQ_FETCH) && found_w[DEPTH]) |=> (count_r < CNT_W'(DEPTH)))
    else $error("delivery did not free a slot");

endmodule
